>>> hw/rtl/byterun1_row_unpacker_assert.svh
// ---------------------------------------------------------------------------
// byterun1 row unpacker assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef BYTERUN1_ROW_UNPACKER_ASSERT_SVH
`define BYTERUN1_ROW_UNPACKER_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define BYRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BYRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/byru_pkg.sv
// ---------------------------------------------------------------------------
// byru_pkg
// shared types and constants of the byterun1 row unpacker
// ---------------------------------------------------------------------------
`default_nettype none

package byru_pkg;

    localparam int DEF_MAX_ROW_BYTES = 4096;
    localparam int DEF_QUEUE_DEPTH   = 2;

    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic CFG_MODE     = 1'b0;
    localparam logic CFG_ROW_BYTES = 1'b1;

    // compression modes
    localparam logic [7:0] MODE_COPY = 8'd0;
    localparam logic [7:0] MODE_RLE  = 8'd1;

    localparam logic [7:0]  RESET_MODE      = MODE_RLE;
    localparam logic [12:0] RESET_ROW_BYTES = 13'd40;

    // skip control byte (-128)
    localparam logic [7:0] CTRL_SKIP = 8'h80;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_MID_ROW = 2'd2;
    localparam logic [1:0] ERR_MODE    = 2'd3;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP,
        PH_DROP
    } phase_t;

    // one unit of work for the output side: nbytes copies of data
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] nbytes;
        logic       row_end;
        logic [1:0] err;
    } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/byru_queue.sv
// ---------------------------------------------------------------------------
// byru_queue
// small command fifo between the classifier and the expander
// ---------------------------------------------------------------------------
`default_nettype none

module byru_queue import byru_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/byru_front.sv
// ---------------------------------------------------------------------------
// byru_front
// takes packed bytes, tracks run and row state, issues expand commands
// ---------------------------------------------------------------------------
`default_nettype none

module byru_front import byru_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            src_byte,
    input  wire logic                  source_last,
    output logic                       cmd_valid,
    input  wire logic                  cmd_ready,
    output cmd_t                       cmd
);

    localparam int LW = $clog2(MAX_ROW_BYTES + 1);

    function automatic logic [LW-1:0] full_row(input logic [12:0] rb);
        logic [LW-1:0] r;
        if (rb == '0) begin
            r = LW'(1);
        end else if (32'(rb) > 32'(MAX_ROW_BYTES)) begin
            r = LW'(MAX_ROW_BYTES);
        end else begin
            r = LW'(rb);
        end
        return r;
    endfunction

    logic [7:0]    mode_reg, mode_next;
    logic [12:0]   row_bytes_reg, row_bytes_next;
    phase_t        phase_reg, phase_next;
    logic [7:0]    run_reg, run_next;
    logic [LW-1:0] row_reg, row_next;

    logic [LW-1:0] full_cur, full_new;
    logic          accept;

    // per-item decision before the end-of-source check
    phase_t        ph_upd;
    logic [7:0]    run_upd;
    logic [LW-1:0] row_upd;
    logic          emit_pre;
    cmd_t          cmd_pre;
    logic [8:0]    ctl_cnt9;
    logic [7:0]    ctl_cnt;
    logic          mid_row;
    logic          any_err;

    assign s_tready = cmd_ready;
    assign accept   = s_tvalid & s_tready;
    assign full_cur = full_row(row_bytes_reg);
    assign full_new = full_row(row_bytes_next);

    // control byte to run length: n+1 for literals, 1-n for repeats
    assign ctl_cnt9 = src_byte[7] ? (9'd257 - {1'b0, src_byte}) : ({1'b0, src_byte} + 9'd1);
    assign ctl_cnt  = ctl_cnt9[7:0];

    always_comb begin
        mode_next      = mode_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MODE:      mode_next      = cfg_wdata[7:0];
                CFG_ROW_BYTES: row_bytes_next = cfg_wdata;
                default:       mode_next      = mode_reg;
            endcase
        end
    end

    // classify one item
    always_comb begin
        ph_upd   = phase_reg;
        run_upd  = run_reg;
        row_upd  = row_reg;
        emit_pre = 1'b0;
        cmd_pre  = '{data: src_byte, nbytes: 8'd0, row_end: 1'b0, err: ERR_NONE};
        if (mode_reg > MODE_RLE) begin
            emit_pre    = 1'b1;
            cmd_pre.err = ERR_MODE;
        end else if (mode_reg == MODE_COPY || phase_reg == PH_LIT) begin
            emit_pre       = 1'b1;
            cmd_pre.nbytes = 8'd1;
            if (row_reg == LW'(1)) begin
                cmd_pre.row_end = 1'b1;
                row_upd         = full_cur;
            end else begin
                row_upd = row_reg - LW'(1);
            end
            if (mode_reg != MODE_COPY) begin
                run_upd = run_reg - 8'd1;
                if (run_reg == 8'd1) begin
                    ph_upd = PH_CTRL;
                end
            end
        end else if (phase_reg == PH_REP) begin
            emit_pre       = 1'b1;
            cmd_pre.nbytes = run_reg;
            // a repeat never crosses a row: it was checked against row_reg
            if (32'(run_reg) == 32'(row_reg)) begin
                cmd_pre.row_end = 1'b1;
                row_upd         = full_cur;
            end else begin
                row_upd = row_reg - LW'(run_reg);
            end
            run_upd = 8'd0;
            ph_upd  = PH_CTRL;
        end else if (src_byte != CTRL_SKIP) begin
            if (32'(ctl_cnt) > 32'(row_reg)) begin
                emit_pre    = 1'b1;
                cmd_pre.err = ERR_OVERRUN;
            end else begin
                run_upd = ctl_cnt;
                ph_upd  = src_byte[7] ? PH_REP : PH_LIT;
            end
        end
    end

    assign mid_row = source_last && (cmd_pre.err == ERR_NONE) && (phase_reg != PH_DROP)
                     && !(ph_upd == PH_CTRL && row_upd == full_cur);
    assign any_err = mid_row || (emit_pre && cmd_pre.err != ERR_NONE);

    // command output
    always_comb begin
        cmd       = cmd_pre;
        cmd_valid = 1'b0;
        if (accept && phase_reg != PH_DROP) begin
            cmd_valid = emit_pre || mid_row;
            if (mid_row) begin
                cmd.err = ERR_MID_ROW;
            end
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        run_next   = run_reg;
        row_next   = row_reg;
        if (cfg_wr_en) begin
            phase_next = PH_CTRL;
            run_next   = 8'd0;
            row_next   = full_new;
        end else if (accept) begin
            if (source_last) begin
                phase_next = PH_CTRL;
                run_next   = 8'd0;
                row_next   = full_cur;
            end else if (phase_reg == PH_DROP) begin
                phase_next = PH_DROP;
            end else if (any_err) begin
                phase_next = PH_DROP;
                run_next   = 8'd0;
                row_next   = row_upd;
            end else begin
                phase_next = ph_upd;
                run_next   = run_upd;
                row_next   = row_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= RESET_MODE;
            row_bytes_reg <= RESET_ROW_BYTES;
            phase_reg     <= PH_CTRL;
            run_reg       <= 8'd0;
            row_reg       <= full_row(RESET_ROW_BYTES);
        end else begin
            mode_reg      <= mode_next;
            row_bytes_reg <= row_bytes_next;
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            row_reg       <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/byru_back.sv
// ---------------------------------------------------------------------------
// byru_back
// expands commands into results of up to two bytes, output register
// ---------------------------------------------------------------------------
`default_nettype none

module byru_back import byru_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] byte_first,
    output logic [7:0] byte_second,
    output logic [1:0] byte_count,
    output logic       row_end,
    output logic [1:0] error_code,
    output logic       last_of_run
);

    logic       active_reg, active_next;
    cmd_t       cur_reg, cur_next;
    logic       vld_reg, vld_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       rend_reg, rend_next;
    logic [1:0] err_reg, err_next;
    logic       last_reg, last_next;

    logic       can_emit;
    logic [1:0] take;
    logic       fin;

    assign take      = (cur_reg.nbytes >= 8'd2) ? 2'd2 : cur_reg.nbytes[1:0];
    assign fin       = (cur_reg.nbytes <= 8'd2);
    assign can_emit  = active_reg && (!vld_reg || m_tready);
    // next command loads as the current one sends its final result
    assign cmd_ready = !active_reg || (can_emit && fin);

    always_comb begin
        active_next = active_reg;
        cur_next    = cur_reg;
        vld_next    = vld_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        cnt_next    = cnt_reg;
        rend_next   = rend_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        if (can_emit) begin
            vld_next        = 1'b1;
            b1_next         = (take == 2'd0) ? 8'd0 : cur_reg.data;
            b2_next         = (take == 2'd2) ? cur_reg.data : 8'd0;
            cnt_next        = take;
            rend_next       = fin & cur_reg.row_end;
            err_next        = fin ? cur_reg.err : ERR_NONE;
            last_next       = fin;
            cur_next.nbytes = cur_reg.nbytes - 8'(take);
            active_next     = !fin;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
        if (cmd_ready && cmd_valid) begin
            active_next = 1'b1;
            cur_next    = cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end else begin
            active_reg <= active_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        cnt_reg  <= cnt_next;
        rend_reg <= rend_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign m_tvalid    = vld_reg;
    assign byte_first  = b1_reg;
    assign byte_second = b2_reg;
    assign byte_count  = cnt_reg;
    assign row_end     = rend_reg;
    assign error_code  = err_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/byterun1_row_unpacker.sv
// Unpacks a packbits (byterun1) byte stream into rows of row_bytes bytes. One packed
// byte is taken per cycle while the command queue has room; the classifier decides run
// and row state at once. The expander sends one result per cycle unless the output is
// stalled: a literal or copied byte is one result, a repeat of n bytes is ceil(n/2)
// results, so a repeat can hold the input back once the queue is full. An accepted
// byte passes the queue, the expander's command register and the output register, and
// waits while the expander is busy or the output is stalled. Control and skip bytes
// give no result unless they carry an error; bytes dropped after an error give none.
// ---------------------------------------------------------------------------
// byterun1_row_unpacker
// top level: classifier, command queue, expander
// ---------------------------------------------------------------------------
`default_nettype none

module byterun1_row_unpacker import byru_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // src_byte
    input  wire logic                  s_tlast,   // source_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // byte_first, byte_second, byte_count, row_end
    output logic [1:0]                 m_tuser,   // error_code
    output logic                       m_tlast    // last_of_run
);

    logic       f_valid, f_ready;
    cmd_t       f_cmd;
    logic       q_valid, q_ready;
    cmd_t       q_cmd;
    logic [7:0] byte_first, byte_second;
    logic [1:0] byte_count;
    logic       row_end;

    byru_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .src_byte    (s_tdata),
        .source_last (s_tlast),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd         (f_cmd)
    );

    byru_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    byru_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .byte_first  (byte_first),
        .byte_second (byte_second),
        .byte_count  (byte_count),
        .row_end     (row_end),
        .error_code  (m_tuser),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {5'd0, row_end, byte_count, byte_second, byte_first};

endmodule

`default_nettype wire

>>> hw/rtl/byru_checker.sv
// ---------------------------------------------------------------------------
// byru_checker
// port-level checks on the unpacker result stream
// ---------------------------------------------------------------------------
`default_nettype none

`include "byterun1_row_unpacker_assert.svh"

module byru_checker import byru_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic [1:0] word_cnt;
    logic [7:0] word_b2;
    logic       bare_err;

    assign word_cnt = m_tdata[17:16];
    assign word_b2  = m_tdata[15:8];
    assign bare_err = (m_tuser == ERR_OVERRUN) || (m_tuser == ERR_MODE);

    // a stalled word stays offered
    `BYRU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    // errors only ride on the final word of an input
    `BYRU_ASSERT_NOW(a_err_last, m_tvalid && m_tuser != ERR_NONE, m_tlast, "early error word")
    `BYRU_ASSERT_NOW(a_cnt, m_tvalid, word_cnt != 2'd3, "byte count out of range")
    // an unused second byte lane is zero
    `BYRU_ASSERT_NOW(a_pad, m_tvalid && word_cnt != 2'd2, word_b2 == 8'd0, "stray second byte")
    // bad-mode and overrun errors carry no bytes
    `BYRU_ASSERT_NOW(a_err_empty, m_tvalid && bare_err, word_cnt == 2'd0, "error word with bytes")

endmodule

bind byterun1_row_unpacker byru_checker u_byru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
